@@ rtl/ssc_pkg.sv @@
// ssc_pkg: shared types, status codes and helpers for the sphere contact pipeline
// no dependencies; used by every module under rtl/
`timescale 1ns / 1ps

package ssc_pkg;

  // result status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // unit length in Q2.30, used for the fallback normal
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // radicand width of the square root pipeline, root has half the bits
  localparam int RAD_W = 64;
  // quotient bits of the normal divider
  localparam int QUO_W = 31;

  // side data carried through the square root pipeline
  typedef struct packed {
    logic [1:0]       status;
    logic             zero;
    logic [2:0][31:0] ac;
    logic [31:0]      ra;
    logic [32:0]      rs;
    logic [2:0][31:0] ms;
    logic [2:0]       neg;
  } sq_side_t;

  // side data carried through the divider
  typedef struct packed {
    logic [1:0]       status;
    logic             zero;
    logic [2:0][31:0] ac;
    logic [31:0]      ra;
    logic [32:0]      rs;
    logic [32:0]      rr;
    logic [2:0]       neg;
  } div_side_t;

  localparam int SQ_SIDE_W  = $bits(sq_side_t);
  localparam int DIV_SIDE_W = $bits(div_side_t);

  // left shift that brings a nonzero largest magnitude below 2^31 into [2^30, 2^31); zero if bit 31 is set
  function automatic logic [4:0] norm_shift(input logic [31:0] mx);
    logic [4:0] s;
    s = 5'd0;
    if (!mx[31]) begin
      for (int i = 0; i < 31; i++) begin
        if (mx[i]) s = 5'(30 - i);
      end
    end
    return s;
  endfunction

endpackage

@@ rtl/ssc_front.sv @@
// ssc_front: deltas, squared distance, contact test and normalized squares
// depends on ssc_pkg
`timescale 1ns / 1ps

module ssc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [2:0][31:0]       a_c,
  input  logic [2:0][31:0]       b_c,
  input  logic [31:0]            a_r,
  input  logic [31:0]            b_r,
  output logic                   out_valid,
  output logic [63:0]            d2,
  output logic [63:0]            d2s,
  output ssc_pkg::sq_side_t      side
);

  logic [7:1] vld;

  // stage 1
  logic [2:0][32:0] d1;
  logic [32:0]      rs1;
  logic             inv1;
  logic [2:0][31:0] ac1;
  logic [31:0]      ra1;
  // stage 2
  logic [2:0][31:0] m2;
  logic [2:0]       neg2;
  logic [32:0]      rs2;
  logic             inv2;
  logic [2:0][31:0] ac2;
  logic [31:0]      ra2;
  // stage 3
  logic [2:0][63:0] sq3;
  logic [65:0]      rsq3;
  logic [31:0]      mx3;
  logic [2:0][31:0] m3;
  logic [2:0]       neg3;
  logic [32:0]      rs3;
  logic             inv3;
  logic [2:0][31:0] ac3;
  logic [31:0]      ra3;
  // stage 4
  logic [65:0]      d2_4;
  logic [65:0]      rsq4;
  logic [4:0]       s4;
  logic [2:0][31:0] m4;
  logic [2:0]       neg4;
  logic [32:0]      rs4;
  logic             inv4;
  logic [2:0][31:0] ac4;
  logic [31:0]      ra4;
  // stage 5
  logic [63:0]      d2_5;
  logic [2:0][31:0] ms5;
  logic [1:0]       st5;
  logic             zero5;
  logic [2:0]       neg5;
  logic [32:0]      rs5;
  logic [2:0][31:0] ac5;
  logic [31:0]      ra5;
  // stage 6
  logic [63:0]      d2_6;
  logic [2:0][63:0] sqs6;
  logic [2:0][31:0] ms6;
  logic [1:0]       st6;
  logic             zero6;
  logic [2:0]       neg6;
  logic [32:0]      rs6;
  logic [2:0][31:0] ac6;
  logic [31:0]      ra6;
  // stage 7
  logic [63:0]      d2_7;
  logic [63:0]      d2s7;
  ssc_pkg::sq_side_t side7;

  logic [2:0][32:0] negd;
  logic [31:0]      mx_ab;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      negd[i] = 33'd0 - d1[i];
    end
    mx_ab = (m2[1] > m2[0]) ? m2[1] : m2[0];
  end

  always_ff @(posedge clk) begin
    // stage 1: center deltas and radius sum
    for (int i = 0; i < 3; i++) begin
      d1[i] <= {b_c[i][31], b_c[i]} - {a_c[i][31], a_c[i]};
    end
    rs1  <= {1'b0, a_r} + {1'b0, b_r};
    inv1 <= a_r[31] | b_r[31];
    ac1  <= a_c;
    ra1  <= a_r;

    // stage 2: magnitudes
    for (int i = 0; i < 3; i++) begin
      m2[i]   <= d1[i][32] ? negd[i][31:0] : d1[i][31:0];
      neg2[i] <= d1[i][32];
    end
    rs2  <= rs1;
    inv2 <= inv1;
    ac2  <= ac1;
    ra2  <= ra1;

    // stage 3: squares and largest magnitude
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= m2[i] * m2[i];
    end
    rsq3 <= {33'd0, rs2} * {33'd0, rs2};
    mx3  <= (m2[2] > mx_ab) ? m2[2] : mx_ab;
    m3   <= m2;
    neg3 <= neg2;
    rs3  <= rs2;
    inv3 <= inv2;
    ac3  <= ac2;
    ra3  <= ra2;

    // stage 4: squared distance and normalizing shift
    d2_4 <= {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};
    s4   <= ssc_pkg::norm_shift(mx3);
    rsq4 <= rsq3;
    m4   <= m3;
    neg4 <= neg3;
    rs4  <= rs3;
    inv4 <= inv3;
    ac4  <= ac3;
    ra4  <= ra3;

    // stage 5: classify and scale the magnitudes
    if (inv4) begin
      st5 <= ssc_pkg::ST_BAD;
    end else if (d2_4[65:64] != 2'b00) begin
      st5 <= ssc_pkg::ST_OVF;
    end else if (d2_4 > rsq4) begin
      st5 <= ssc_pkg::ST_NONE;
    end else begin
      st5 <= ssc_pkg::ST_HIT;
    end
    zero5 <= (d2_4 == 66'd0);
    d2_5  <= d2_4[63:0];
    for (int i = 0; i < 3; i++) begin
      ms5[i] <= m4[i] << s4;
    end
    neg5 <= neg4;
    rs5  <= rs4;
    ac5  <= ac4;
    ra5  <= ra4;

    // stage 6: squares of the scaled magnitudes
    for (int i = 0; i < 3; i++) begin
      sqs6[i] <= ms5[i] * ms5[i];
    end
    d2_6  <= d2_5;
    ms6   <= ms5;
    st6   <= st5;
    zero6 <= zero5;
    neg6  <= neg5;
    rs6   <= rs5;
    ac6   <= ac5;
    ra6   <= ra5;

    // stage 7: scaled squared distance
    d2s7         <= sqs6[0] + sqs6[1] + sqs6[2];
    d2_7         <= d2_6;
    side7.status <= st6;
    side7.zero   <= zero6;
    side7.ac     <= ac6;
    side7.ra     <= ra6;
    side7.rs     <= rs6;
    side7.ms     <= ms6;
    side7.neg    <= neg6;
  end

  assign out_valid = vld[7];
  assign d2        = d2_7;
  assign d2s       = d2s7;
  assign side      = side7;

endmodule

@@ rtl/ssc_sqrt.sv @@
// ssc_sqrt: two-lane pipelined integer square root, one root bit per stage
// depends on ssc_pkg; gives floor root and remainder for each lane
`timescale 1ns / 1ps

module ssc_sqrt #(
  parameter int SIDE_W = ssc_pkg::SQ_SIDE_W
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [1:0][ssc_pkg::RAD_W-1:0]         rad_in,
  input  logic [SIDE_W-1:0]                      side_in,
  output logic                                   out_valid,
  output logic [1:0][ssc_pkg::RAD_W/2-1:0]       root_out,
  output logic [1:0][ssc_pkg::RAD_W/2:0]         rem_out,
  output logic [SIDE_W-1:0]                      side_out
);

  localparam int NSTG = ssc_pkg::RAD_W / 2;

  logic                   vld  [0:NSTG];
  logic [NSTG:0]          rem  [0:NSTG][0:1];
  logic [NSTG-1:0]        root [0:NSTG][0:1];
  logic [2*NSTG-1:0]      rad  [0:NSTG][0:1];
  logic [SIDE_W-1:0]      side [0:NSTG];

  // stage zero is the module input, not registered
  always_comb begin
    vld[0]  = in_valid;
    side[0] = side_in;
    for (int l = 0; l < 2; l++) begin
      rem[0][l]  = '0;
      root[0][l] = '0;
      rad[0][l]  = rad_in[l];
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NSTG+2:0] trial;
      logic [NSTG+2:0] test;

      // bring down two radicand bits and try the next root bit
      always_comb begin
        trial = {rem[k][l], rad[k][l][2*NSTG-1 -: 2]};
        test  = {1'b0, root[k][l], 2'b01};
      end

      always_ff @(posedge clk) begin
        if (trial >= test) begin
          rem[k+1][l]  <= (NSTG+1)'(trial - test);
          root[k+1][l] <= {root[k][l][NSTG-2:0], 1'b1};
        end else begin
          rem[k+1][l]  <= trial[NSTG:0];
          root[k+1][l] <= {root[k][l][NSTG-2:0], 1'b0};
        end
        rad[k+1][l] <= {rad[k][l][2*NSTG-3:0], 2'b00};
      end
    end
  end

  always_comb begin
    out_valid = vld[NSTG];
    side_out  = side[NSTG];
    for (int l = 0; l < 2; l++) begin
      root_out[l] = root[NSTG][l];
      rem_out[l]  = rem[NSTG][l];
    end
  end

endmodule

@@ rtl/ssc_div.sv @@
// ssc_div: three-lane pipelined restoring divider with a shared divisor
// depends on ssc_pkg; one quotient bit per stage
`timescale 1ns / 1ps

module ssc_div #(
  parameter int SIDE_W = ssc_pkg::DIV_SIDE_W
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  logic [2:0][2*ssc_pkg::QUO_W:0]            num_in,
  input  logic [ssc_pkg::QUO_W:0]                   den_in,
  input  logic [SIDE_W-1:0]                         side_in,
  output logic                                      out_valid,
  output logic [2:0][ssc_pkg::QUO_W-1:0]            quo_out,
  output logic [SIDE_W-1:0]                         side_out
);

  localparam int NQ = ssc_pkg::QUO_W;

  logic              vld  [0:NQ];
  logic [NQ:0]       den  [0:NQ];
  logic [SIDE_W-1:0] side [0:NQ];
  logic [NQ:0]       rem  [0:NQ][0:2];
  logic [NQ-1:0]     low  [0:NQ][0:2];
  logic [NQ-1:0]     quo  [0:NQ][0:2];

  // split the dividend into the starting remainder and the bits still to come
  always_comb begin
    vld[0]  = in_valid;
    den[0]  = den_in;
    side[0] = side_in;
    for (int l = 0; l < 3; l++) begin
      rem[0][l] = num_in[l][2*NQ:NQ];
      low[0][l] = num_in[l][NQ-1:0];
      quo[0][l] = '0;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NQ+1:0] trial;

      always_comb begin
        trial = {rem[k][l], low[k][l][NQ-1]};
      end

      // subtract the divisor where it fits
      always_ff @(posedge clk) begin
        if (trial >= {1'b0, den[k]}) begin
          rem[k+1][l] <= (NQ+1)'(trial - {1'b0, den[k]});
          quo[k+1][l] <= {quo[k][l][NQ-2:0], 1'b1};
        end else begin
          rem[k+1][l] <= trial[NQ:0];
          quo[k+1][l] <= {quo[k][l][NQ-2:0], 1'b0};
        end
        low[k+1][l] <= {low[k][l][NQ-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    out_valid = vld[NQ];
    side_out  = side[NQ];
    for (int l = 0; l < 3; l++) begin
      quo_out[l] = quo[NQ][l];
    end
  end

endmodule

@@ rtl/ssc_back.sv @@
// ssc_back: signed normal, depth, contact point offset, saturation and result registers
// depends on ssc_pkg
`timescale 1ns / 1ps

module ssc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [2:0][30:0]        quo,
  input  ssc_pkg::div_side_t      side,
  output logic                    out_valid,
  output logic [1:0]              status,
  output logic [2:0][31:0]        normal,
  output logic [31:0]             depth,
  output logic [2:0][31:0]        point
);

  logic [6:1] vld;

  // stage 1
  logic [2:0][31:0] n1;
  logic [31:0]      dp1;
  logic [1:0]       st1;
  logic [2:0][31:0] ac1;
  logic [31:0]      ra1;
  // stage 2
  logic signed [33:0] t2;
  logic [2:0][31:0] n2;
  logic [31:0]      dp2;
  logic [1:0]       st2;
  logic [2:0][31:0] ac2;
  // stage 3
  logic signed [65:0] prod3 [0:2];
  logic [2:0][31:0] n3;
  logic [31:0]      dp3;
  logic [1:0]       st3;
  logic [2:0][31:0] ac3;
  // stage 4
  logic [62:0]      pm4 [0:2];
  logic [2:0]       ng4;
  logic [2:0][31:0] n4;
  logic [31:0]      dp4;
  logic [1:0]       st4;
  logic [2:0][31:0] ac4;
  // stage 5
  logic [32:0]      q5 [0:2];
  logic [2:0]       ng5;
  logic [2:0][31:0] n5;
  logic [31:0]      dp5;
  logic [1:0]       st5;
  logic [2:0][31:0] ac5;
  // stage 6, result registers
  logic [1:0]       st6;
  logic [2:0][31:0] n6;
  logic [31:0]      dp6;
  logic [2:0][31:0] pt6;

  logic [2:0][31:0] qn;
  logic [65:0]      pneg [0:2];
  logic [63:0]      qsum [0:2];
  logic signed [34:0] psum [0:2];
  logic             hit5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:1], in_valid};
    end
  end

  always_comb begin
    hit5 = (st5 == ssc_pkg::ST_HIT);
    for (int i = 0; i < 3; i++) begin
      qn[i]   = 32'd0 - {1'b0, quo[i]};
      pneg[i] = 66'd0 - prod3[i];
      qsum[i] = {1'b0, pm4[i]} + 64'h0000_0000_4000_0000;
      if (ng5[i]) begin
        psum[i] = $signed({{3{ac5[i][31]}}, ac5[i]}) - $signed({2'b00, q5[i]});
      end else begin
        psum[i] = $signed({{3{ac5[i][31]}}, ac5[i]}) + $signed({2'b00, q5[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: signed normal and depth, fixed +x axis for coincident centers
    for (int i = 0; i < 3; i++) begin
      if (side.zero) begin
        n1[i] <= (i == 0) ? ssc_pkg::ONE_Q30 : 32'd0;
      end else begin
        n1[i] <= side.neg[i] ? qn[i] : {1'b0, quo[i]};
      end
    end
    dp1 <= side.zero ? side.rs[31:0] : 32'(side.rs - side.rr);
    st1 <= side.status;
    ac1 <= side.ac;
    ra1 <= side.ra;

    // stage 2: lever from the normal to the midpoint, 2*ra - depth
    t2  <= $signed({1'b0, ra1, 1'b0}) - $signed({2'b00, dp1});
    n2  <= n1;
    dp2 <= dp1;
    st2 <= st1;
    ac2 <= ac1;

    // stage 3: offset products
    for (int i = 0; i < 3; i++) begin
      prod3[i] <= $signed(n2[i]) * t2;
    end
    n3  <= n2;
    dp3 <= dp2;
    st3 <= st2;
    ac3 <= ac2;

    // stage 4: magnitudes
    for (int i = 0; i < 3; i++) begin
      pm4[i] <= prod3[i][65] ? pneg[i][62:0] : prod3[i][62:0];
      ng4[i] <= prod3[i][65];
    end
    n4  <= n3;
    dp4 <= dp3;
    st4 <= st3;
    ac4 <= ac3;

    // stage 5: round to Q16.16, ties away from zero
    for (int i = 0; i < 3; i++) begin
      q5[i] <= qsum[i][63:31];
    end
    ng5 <= ng4;
    n5  <= n4;
    dp5 <= dp4;
    st5 <= st4;
    ac5 <= ac4;

    // stage 6: add to center a, saturate, clear fields without contact
    for (int i = 0; i < 3; i++) begin
      if (!hit5) begin
        pt6[i] <= 32'd0;
      end else if (psum[i] > 35'sd2147483647) begin
        pt6[i] <= 32'h7fff_ffff;
      end else if (psum[i] < -35'sd2147483648) begin
        pt6[i] <= 32'h8000_0000;
      end else begin
        pt6[i] <= psum[i][31:0];
      end
      n6[i] <= hit5 ? n5[i] : 32'd0;
    end
    dp6 <= hit5 ? dp5 : 32'd0;
    st6 <= st5;
  end

  assign out_valid = vld[6];
  assign status    = st6;
  assign normal    = n6;
  assign depth     = dp6;
  assign point     = pt6;

endmodule

@@ rtl/sphere_sphere_contact.sv @@
// sphere_sphere_contact: top level of the sphere pair contact pipeline
// depends on ssc_pkg, ssc_front, ssc_sqrt, ssc_div, ssc_back
`timescale 1ns / 1ps

// channel   signals                                     handshake
// --------  ------------------------------------------  ---------------------------
// request   a_center_*, a_radius, b_center_*, b_radius  start high while busy low
// result    status, normal_*, depth, point_*            done high for one cycle
//
// one request enters per cycle; busy stays low since the pipeline never stalls
// each result passes through 7 front stages, 32 root stages, 1 rounding stage,
// 31 divider stages and 6 back stages
// reset clears only the valid bits; data registers hold whatever they last had
// the receiver cannot stall, so every done pulse must be taken as it comes

module sphere_sphere_contact (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] a_center_x,
  input  logic [31:0] a_center_y,
  input  logic [31:0] a_center_z,
  input  logic [31:0] a_radius,
  input  logic [31:0] b_center_x,
  input  logic [31:0] b_center_y,
  input  logic [31:0] b_center_z,
  input  logic [31:0] b_radius,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] normal_x,
  output logic [31:0] normal_y,
  output logic [31:0] normal_z,
  output logic [31:0] depth,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z
);

  logic                  fr_valid;
  logic [63:0]           fr_d2;
  logic [63:0]           fr_d2s;
  ssc_pkg::sq_side_t     fr_side;

  logic                  sq_valid;
  logic [1:0][31:0]      sq_root;
  logic [1:0][32:0]      sq_rem;
  logic [ssc_pkg::SQ_SIDE_W-1:0] sq_side_raw;
  ssc_pkg::sq_side_t     sq_side;

  logic                  md_valid;
  logic [2:0][62:0]      md_num;
  logic [31:0]           md_den;
  ssc_pkg::div_side_t    md_side;

  logic                  dv_valid;
  logic [2:0][30:0]      dv_quo;
  logic [ssc_pkg::DIV_SIDE_W-1:0] dv_side_raw;

  logic [2:0][31:0]      normal;
  logic [2:0][31:0]      point;
  logic                  req;

  assign busy = 1'b0;
  assign req  = start & ~busy;

  // deltas, squared distance and contact test
  ssc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req),
    .a_c       ({a_center_z, a_center_y, a_center_x}),
    .b_c       ({b_center_z, b_center_y, b_center_x}),
    .a_r       (a_radius),
    .b_r       (b_radius),
    .out_valid (fr_valid),
    .d2        (fr_d2),
    .d2s       (fr_d2s),
    .side      (fr_side)
  );

  // distance in lane 0, normalizing length in lane 1
  ssc_sqrt #(
    .SIDE_W (ssc_pkg::SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .rad_in    ({fr_d2s, fr_d2}),
    .side_in   (fr_side),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .rem_out   (sq_rem),
    .side_out  (sq_side_raw)
  );

  assign sq_side = ssc_pkg::sq_side_t'(sq_side_raw);

  // round the distance and form the rounded dividends
  always_ff @(posedge clk) begin
    if (rst) begin
      md_valid <= 1'b0;
    end else begin
      md_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      md_num[i] <= {1'b0, sq_side.ms[i], 30'd0} + {32'd0, sq_root[1][31:1]};
    end
    md_den         <= sq_root[1];
    md_side.rr     <= {1'b0, sq_root[0]} + 33'(sq_rem[0] > {1'b0, sq_root[0]});
    md_side.status <= sq_side.status;
    md_side.zero   <= sq_side.zero;
    md_side.ac     <= sq_side.ac;
    md_side.ra     <= sq_side.ra;
    md_side.rs     <= sq_side.rs;
    md_side.neg    <= sq_side.neg;
  end

  // normal components
  ssc_div #(
    .SIDE_W (ssc_pkg::DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (md_valid),
    .num_in    (md_num),
    .den_in    (md_den),
    .side_in   (md_side),
    .out_valid (dv_valid),
    .quo_out   (dv_quo),
    .side_out  (dv_side_raw)
  );

  // depth, contact point and result registers
  ssc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .quo       (dv_quo),
    .side      (ssc_pkg::div_side_t'(dv_side_raw)),
    .out_valid (done),
    .status    (status),
    .normal    (normal),
    .depth     (depth),
    .point     (point)
  );

  assign normal_x = normal[0];
  assign normal_y = normal[1];
  assign normal_z = normal[2];
  assign point_x  = point[0];
  assign point_y  = point[1];
  assign point_z  = point[2];

endmodule

@@ test/sphere_sphere_contact_test.sv @@
// sphere_sphere_contact_test: self-checking bench for the sphere pair contact pipeline
// depends on ssc_pkg and sphere_sphere_contact; predicts every result in exact integers
`timescale 1ns / 1ps

module sphere_sphere_contact_test;

  // one expected contact result
  typedef struct {
    logic [1:0]  status;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
    logic [31:0] depth;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
  } contact_t;

  localparam int IDLE_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] a_center_x = '0;
  logic [31:0] a_center_y = '0;
  logic [31:0] a_center_z = '0;
  logic [31:0] a_radius = '0;
  logic [31:0] b_center_x = '0;
  logic [31:0] b_center_y = '0;
  logic [31:0] b_center_z = '0;
  logic [31:0] b_radius = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] normal_x;
  logic [31:0] normal_y;
  logic [31:0] normal_z;
  logic [31:0] depth;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  contact_t pending_contacts[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  bit       allow_gaps = 1'b1;

  sphere_sphere_contact dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_center_x(a_center_x), .a_center_y(a_center_y), .a_center_z(a_center_z),
    .a_radius(a_radius),
    .b_center_x(b_center_x), .b_center_y(b_center_y), .b_center_z(b_center_z),
    .b_radius(b_radius),
    .done(done), .status(status),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .depth(depth), .point_x(point_x), .point_y(point_y), .point_z(point_z)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // floor of the square root of a 64-bit value
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned b_;
    res = 0;
    b_ = 64'd1 << 62;
    while (b_ > v) b_ >>= 2;
    while (b_ != 0) begin
      if (v >= res + b_) begin
        v -= res + b_;
        res = (res >> 1) + b_;
      end else begin
        res >>= 1;
      end
      b_ >>= 2;
    end
    return res;
  endfunction

  // exact contact computation for one sphere pair
  function automatic contact_t predict_contact(input logic [31:0] ax, ay, az, ar,
                                               input logic [31:0] bx, by, bz, br);
    contact_t        r;
    longint          ac[3];
    longint          bc[3];
    longint          dl[3];
    longint          nrm[3];
    longint unsigned mg[3];
    longint unsigned ms[3];
    longint unsigned sq, d2, d2s, rs, cdist, dep, mx, den, q, pm;
    longint          ra, rb, t2, prod, off, pt;
    logic [64:0]     acc;
    bit              ovf;
    int              s;
    r = '{default: '0};
    ac[0] = longint'($signed(ax)); ac[1] = longint'($signed(ay));
    ac[2] = longint'($signed(az));
    bc[0] = longint'($signed(bx)); bc[1] = longint'($signed(by));
    bc[2] = longint'($signed(bz));
    ra = longint'($signed(ar));
    rb = longint'($signed(br));
    if (ra < 0 || rb < 0) begin
      r.status = ssc_pkg::ST_BAD;
      return r;
    end
    d2 = 0;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = bc[i] - ac[i];
      mg[i] = dl[i] < 0 ? longint'(-dl[i]) : dl[i];
      sq = mg[i] * mg[i];
      acc = {1'b0, d2} + {1'b0, sq};
      if (acc[64]) ovf = 1'b1;
      d2 = acc[63:0];
    end
    if (ovf) begin
      r.status = ssc_pkg::ST_OVF;
      return r;
    end
    rs = longint'(ra) + longint'(rb);
    if (d2 > rs * rs) begin
      r.status = ssc_pkg::ST_NONE;
      return r;
    end
    if (d2 > 0) begin
      cdist = root_floor(d2);
      if (d2 - cdist * cdist > cdist) cdist++;
      dep = rs - cdist;
      mx = mg[0];
      if (mg[1] > mx) mx = mg[1];
      if (mg[2] > mx) mx = mg[2];
      s = 0;
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        s++;
      end
      d2s = 0;
      for (int i = 0; i < 3; i++) begin
        ms[i] = mg[i] << s;
        d2s += ms[i] * ms[i];
      end
      den = root_floor(d2s);
      for (int i = 0; i < 3; i++) begin
        q = ((ms[i] << 30) + (den >> 1)) / den;
        nrm[i] = dl[i] < 0 ? -longint'(q) : longint'(q);
      end
    end else begin
      dep = rs;
      nrm[0] = longint'(ssc_pkg::ONE_Q30);
      nrm[1] = 0;
      nrm[2] = 0;
    end
    t2 = 2 * ra - longint'(dep);
    r.status = ssc_pkg::ST_HIT;
    r.depth = dep[31:0];
    r.normal_x = nrm[0][31:0];
    r.normal_y = nrm[1][31:0];
    r.normal_z = nrm[2][31:0];
    for (int i = 0; i < 3; i++) begin
      prod = nrm[i] * t2;
      pm = prod < 0 ? longint'(-prod) : prod;
      q = (pm + (64'd1 << 30)) >> 31;
      off = prod < 0 ? -longint'(q) : longint'(q);
      pt = ac[i] + off;
      if (pt > 64'sd2147483647) pt = 64'sd2147483647;
      if (pt < -64'sd2147483648) pt = -64'sd2147483648;
      case (i)
        0: r.point_x = pt[31:0];
        1: r.point_y = pt[31:0];
        default: r.point_z = pt[31:0];
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    mismatch_count++;
  endtask

  // send one request and record its expected result when it is taken
  task automatic send_pair(input logic [31:0] ax, ay, az, ar,
                           input logic [31:0] bx, by, bz, br);
    int gap;
    a_center_x <= ax; a_center_y <= ay; a_center_z <= az; a_radius <= ar;
    b_center_x <= bx; b_center_y <= by; b_center_z <= bz; b_radius <= br;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_contacts.insert(pending_contacts.size(),
                            predict_contact(ax, ay, az, ar, bx, by, bz, br));
    gap = allow_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    contact_t want;
    if (!rst && done) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected status", 32'(status), 32'd0);
      end else begin
        want = pending_contacts.pop_front();
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (normal_x !== want.normal_x) report_mismatch("normal_x", normal_x, want.normal_x);
        if (normal_y !== want.normal_y) report_mismatch("normal_y", normal_y, want.normal_y);
        if (normal_z !== want.normal_z) report_mismatch("normal_z", normal_z, want.normal_z);
        if (depth !== want.depth) report_mismatch("depth", depth, want.depth);
        if (point_x !== want.point_x) report_mismatch("point_x", point_x, want.point_x);
        if (point_y !== want.point_y) report_mismatch("point_y", point_y, want.point_y);
        if (point_z !== want.point_z) report_mismatch("point_z", point_z, want.point_z);
      end
    end
  end

  // watchdog on cycles with no request and no result taken
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // invalid radius, overflow, miss, touch, coincident centers and extremes
  task automatic test_directed();
    logic [31:0] mn, mxv;
    mn = 32'h8000_0000;
    mxv = 32'h7fff_ffff;
    send_pair(0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'h0001_0000);
    send_pair(0, 0, 0, 32'h0001_0000, 0, 0, 0, mn);
    send_pair(mxv, mxv, mxv, mn, mn, mn, mn, mn);
    send_pair(mn, mn, mn, 0, mxv, mxv, mxv, 0);
    send_pair(mn, 0, 0, mxv, mxv, 0, 0, mxv);
    send_pair(mn, mn, 0, mxv, mxv, mxv, 0, mxv);
    send_pair(0, 0, 0, 32'h0001_0000, 32'h0010_0000, 0, 0, 32'h0001_0000);
    send_pair(0, 0, 0, 32'h0001_0000, 32'h0003_0000, 0, 0, 32'h0002_0000);
    send_pair(0, 0, 0, 32'h0001_0000, 0, 32'hfffd_0000, 0, 32'h0002_0000);
    send_pair(0, 0, 0, 32'h0000_0003, 0, 0, 32'h0000_0004, 32'h0000_0002);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(32'h1234_5678, 32'hedcb_a988, 5, 32'h0002_0000,
              32'h1234_5678, 32'hedcb_a988, 5, 32'h0001_0000);
    send_pair(mxv, mxv, mxv, mxv, mxv, mxv, mxv, mxv);
    send_pair(mn, mn, mn, mxv, mn, mn, mn, mxv);
    send_pair(mxv, 0, mn, mxv, 32'h7000_0000, 32'h1000_0000, 32'h9000_0000, mxv);
    send_pair(mn, mxv, 0, mxv, 32'h9000_0000, 32'h7000_0000, 32'h1000_0000, mxv);
    send_pair(0, 0, 0, 32'h0001_0000, 1, 1, 1, 32'h0001_0000);
    send_pair(0, 0, 0, 32'h0001_0000, 32'hffff_ffff, 0, 0, 0);
    send_pair(100, 200, 300, 32'h0000_8000, 32'h0000_4000, 32'hffff_c000, 32'h0000_2000,
              32'h0000_8000);
  endtask

  // mostly near pairs that touch or overlap, with random scale and content
  task automatic test_random_near(input int count);
    logic [31:0] ax, ay, az, ar, br;
    int          k;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) allow_gaps = $urandom_range(0, 2) != 0;
      k = 1 << $urandom_range(0, 30);
      ax = $urandom; ay = $urandom; az = $urandom;
      ar = $urandom_range(0, k);
      br = $urandom_range(0, k);
      send_pair(ax, ay, az, ar,
                ax + $urandom_range(0, k) - k / 2, ay + $urandom_range(0, k) - k / 2,
                az + $urandom_range(0, k) - k / 2, br);
    end
  endtask

  // raw random bits on every field
  task automatic test_random_wide(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) allow_gaps = $urandom_range(0, 2) != 0;
      send_pair($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_near(900);
    test_random_wide(300);
    start <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
